// ----- hw/rtl/ewsp_pkg.sv -----
// Shared types, constants and a helper function of the wheel synchronizing PID block.
package ewsp_pkg;

  typedef struct packed {
    logic       enc_left;
    logic       enc_right;
    logic [7:0] left_cmd;
    logic [7:0] right_cmd;
    logic [7:0] dir_cmd;
    logic [7:0] mode_cmd;
  } ewsp_in_t;

  typedef struct packed {
    logic [23:0] left_drive;
    logic [23:0] right_drive;
    logic [3:0]  bridge_bits;
  } ewsp_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_ERR,
    S_SUM,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_CORR,
    S_DIV,
    S_MUL_L,
    S_MUL_R,
    S_MUL_W,
    S_FIN
  } ewsp_state_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgFwdProp  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFwdInt   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFwdDeriv = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRevProp  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRevInt   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRevDeriv = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgLimit    = 3'd7;

  localparam logic [7:0]  FwdPropReset = 8'd6;
  localparam logic [7:0]  RevPropReset = 8'd2;
  localparam logic [15:0] PeriodReset  = 16'd5000;
  localparam logic [23:0] LimitReset   = 24'd500000;

  localparam logic [7:0] DirFwd  = 8'd1;
  localparam logic [7:0] DirRev  = 8'd2;
  localparam logic [7:0] ModeRun = 8'd1;

  localparam logic [3:0] BridgeFwd  = 4'h5;
  localparam logic [3:0] BridgeRev  = 4'hA;
  localparam logic [3:0] BridgeStop = 4'h0;

  localparam logic signed [31:0] Int32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

  // Saturates a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sh0_7fff_ffff) begin
      r = Int32Max;
    end else if (v < -44'sh0_8000_0000) begin
      r = Int32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ewsp_mul.sv -----
// Shared signed multiplier with a registered product.
module ewsp_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [16:0] b_i,
  output logic signed [50:0] p_o
);

  logic signed [50:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/ewsp_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module ewsp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [23:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] rem_sh;
  logic [17:0] diff;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[23]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign ge     = ~diff[17];

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = 5'd0;
      quo_d  = dividend_i;
      rem_d  = 16'd0;
    end else if (busy_q) begin
      quo_d = {quo_q[22:0], ge};
      rem_d = ge ? diff[15:0] : rem_sh[15:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/encoder_wheel_sync_pid_top.sv -----
// Top level of the wheel synchronizing PID: sequencer, state and configuration.
// Each control tick goes through the count and error updates, three passes
// through the shared 34x17 multiplier for the PID terms, which are summed into
// the correction, a wait on the serial divider that recovers the duty from the
// last left drive as a 24-bit quotient, then the two drive products and the
// final clamp, before its result is written to the output register. No new
// tick is accepted until the sequencer is through with the last one. The input
// is ready only while the sequencer is idle; the result waits in its output
// register, so the next transaction may be accepted while the previous result
// is still pending, and a second result holds the sequencer in its last state
// until the first is taken.
module encoder_wheel_sync_pid_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ewsp_pkg::ewsp_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ewsp_pkg::ewsp_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ewsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ewsp_pkg::CfgDataW-1:0] cfg_data_i
);
  import ewsp_pkg::*;

  ewsp_state_e state_q, state_d;

  logic signed [7:0] fwd_p_q, fwd_i_q, fwd_d_q, rev_p_q, rev_i_q, rev_d_q;
  logic [15:0]       period_q;
  logic [23:0]       limit_q;

  ewsp_in_t          in_q, in_d;
  logic              prev_el_q, prev_el_d, prev_er_q, prev_er_d;
  logic signed [31:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic signed [31:0] errn_q, errn_d, errb_q, errb_d, esum_q, esum_d, corr_q, corr_d;
  logic              start_q, start_d;
  logic [7:0]        last_lc_q, last_lc_d, last_rc_q, last_rc_d;
  logic [23:0]       last_ld_q, last_ld_d;
  logic [3:0]        last_br_q, last_br_d;
  logic              rot_q, rot_d;
  logic signed [43:0] acc_q, acc_d;
  logic signed [50:0] left_q, left_d;
  logic [23:0]       right_q, right_d;
  ewsp_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  logic               div_start, div_done;
  logic [23:0]        div_quot, quot_use;

  logic run, eq, dir_ok, use_pid, out_free;
  logic signed [7:0] kp, ki, kd;
  logic signed [31:0] cnt_lb, cnt_rb;
  logic lrot, rrot;
  logic [23:0] left_clamp, left_fin, right_fin;
  logic [3:0]  bridge_fin;

  assign run      = (in_q.mode_cmd == ModeRun);
  assign eq       = (in_q.left_cmd == in_q.right_cmd);
  assign dir_ok   = (in_q.dir_cmd == DirFwd) || (in_q.dir_cmd == DirRev);
  assign use_pid  = run && eq && (in_q.right_cmd != 8'd0);
  assign out_free = !out_valid_q || out_ready_i;

  assign kp = (in_q.dir_cmd == DirFwd) ? fwd_p_q : rev_p_q;
  assign ki = (in_q.dir_cmd == DirFwd) ? fwd_i_q : rev_i_q;
  assign kd = (in_q.dir_cmd == DirFwd) ? fwd_d_q : rev_d_q;

  assign quot_use = (period_q == 16'd0) ? 24'd0 : div_quot;

  ewsp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ewsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (last_ld_q),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_p_q  <= FwdPropReset;
      fwd_i_q  <= 8'sd0;
      fwd_d_q  <= 8'sd0;
      rev_p_q  <= RevPropReset;
      rev_i_q  <= 8'sd0;
      rev_d_q  <= 8'sd0;
      period_q <= PeriodReset;
      limit_q  <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFwdProp:  fwd_p_q  <= cfg_data_i[7:0];
        CfgFwdInt:   fwd_i_q  <= cfg_data_i[7:0];
        CfgFwdDeriv: fwd_d_q  <= cfg_data_i[7:0];
        CfgRevProp:  rev_p_q  <= cfg_data_i[7:0];
        CfgRevInt:   rev_i_q  <= cfg_data_i[7:0];
        CfgRevDeriv: rev_d_q  <= cfg_data_i[7:0];
        CfgPeriod:   period_q <= cfg_data_i[15:0];
        CfgLimit:    limit_q  <= cfg_data_i;
        default:     limit_q  <= limit_q;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_COUNT;
      S_COUNT: state_d = S_ERR;
      S_ERR:   state_d = S_SUM;
      S_SUM:   state_d = S_MUL_P;
      S_MUL_P: state_d = S_MUL_I;
      S_MUL_I: state_d = S_MUL_D;
      S_MUL_D: state_d = S_ACC;
      S_ACC:   state_d = S_CORR;
      S_CORR:  state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_MUL_L;
      S_MUL_L: state_d = S_MUL_R;
      S_MUL_R: state_d = S_MUL_W;
      S_MUL_W: state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, divider start, handshake.
  always_comb begin
    mul_a      = 34'sd0;
    mul_b      = 17'sd0;
    div_start  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_MUL_P: begin
        mul_a = {{2{errn_q[31]}}, errn_q};
        mul_b = {{9{kp[7]}}, kp};
      end
      S_MUL_I: begin
        mul_a = {{2{esum_q[31]}}, esum_q};
        mul_b = {{9{ki[7]}}, ki};
      end
      S_MUL_D: begin
        mul_a = {{2{errn_q[31]}}, errn_q} - {{2{errb_q[31]}}, errb_q};
        mul_b = {{9{kd[7]}}, kd};
      end
      S_CORR: div_start = 1'b1;
      S_MUL_L: begin
        if (run && eq && !start_q) begin
          mul_a = $signed({10'd0, quot_use}) + $signed({{2{corr_q[31]}}, corr_q});
        end else begin
          mul_a = $signed({26'd0, in_q.left_cmd});
        end
        mul_b = $signed({1'b0, period_q});
      end
      S_MUL_R: begin
        mul_a = $signed({26'd0, in_q.right_cmd});
        mul_b = $signed({1'b0, period_q});
      end
      default: mul_a = 34'sd0;
    endcase
  end

  // Count bases and encoder edges.
  assign cnt_lb = (last_lc_q != last_rc_q) ? 32'sd0 : lcnt_q;
  assign cnt_rb = (last_lc_q != last_rc_q) ? 32'sd0 : rcnt_q;
  assign lrot   = (in_q.enc_left != prev_el_q);
  assign rrot   = (in_q.enc_right != prev_er_q);

  // Final drive values.
  always_comb begin
    if (left_q > $signed({27'd0, limit_q})) begin
      left_clamp = limit_q;
    end else if (left_q < 51'sd0) begin
      left_clamp = 24'd0;
    end else begin
      left_clamp = left_q[23:0];
    end
    if (in_q.dir_cmd == DirFwd) begin
      left_fin = left_clamp;
      right_fin = right_q;
      bridge_fin = BridgeFwd;
    end else if (in_q.dir_cmd == DirRev) begin
      left_fin = left_clamp;
      right_fin = right_q;
      bridge_fin = BridgeRev;
    end else begin
      left_fin = 24'd0;
      right_fin = 24'd0;
      bridge_fin = BridgeStop;
    end
  end

  // Datapath updates.
  always_comb begin
    in_d        = in_q;
    prev_el_d   = prev_el_q;
    prev_er_d   = prev_er_q;
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    errn_d      = errn_q;
    errb_d      = errb_q;
    esum_d      = esum_q;
    corr_d      = corr_q;
    start_d     = start_q;
    last_lc_d   = last_lc_q;
    last_rc_d   = last_rc_q;
    last_ld_d   = last_ld_q;
    last_br_d   = last_br_q;
    rot_d       = rot_q;
    acc_d       = acc_q;
    left_d      = left_q;
    right_d     = right_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: if (in_valid_i) in_d = in_data_i;
      S_COUNT: begin
        if (run && eq) begin
          lcnt_d = (lrot && in_q.enc_left && cnt_lb != Int32Max) ? cnt_lb + 32'sd1 : cnt_lb;
          rcnt_d = (rrot && in_q.enc_right && cnt_rb != Int32Max) ? cnt_rb + 32'sd1 : cnt_rb;
          prev_el_d = in_q.enc_left;
          prev_er_d = in_q.enc_right;
          rot_d = lrot || rrot;
        end
      end
      S_ERR: begin
        if (use_pid) begin
          errb_d = errn_q;
          errn_d = sat32(44'(rcnt_q) - 44'(lcnt_q));
        end
      end
      S_SUM: if (use_pid && rot_q) esum_d = sat32(44'(esum_q) + 44'(errn_q));
      S_MUL_I: acc_d = mul_p[43:0];
      S_MUL_D: acc_d = acc_q + mul_p[43:0];
      S_ACC:   acc_d = acc_q + mul_p[43:0];
      S_CORR: begin
        if (run && eq) begin
          if (in_q.right_cmd == 8'd0) begin
            corr_d = 32'sd0;
          end else if (dir_ok) begin
            corr_d = sat32(acc_q);
          end
        end
      end
      S_MUL_R: left_d = mul_p;
      S_MUL_W: right_d = mul_p[23:0];
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!run) begin
            last_ld_d = 24'd0;
            out_d = '{left_drive: 24'd0, right_drive: 24'd0, bridge_bits: last_br_q};
          end else begin
            // Starting seeds the drive and restarts the loop; a stop clears it too.
            if ((eq && start_q) || !dir_ok) begin
              lcnt_d = 32'sd0;
              rcnt_d = 32'sd0;
              errn_d = 32'sd0;
              errb_d = 32'sd0;
              esum_d = 32'sd0;
            end
            start_d = eq ? 1'b0 : start_q;
            if (left_fin == 24'd0 && right_fin == 24'd0) start_d = 1'b1;
            last_ld_d = left_fin;
            last_br_d = bridge_fin;
            last_lc_d = in_q.left_cmd;
            last_rc_d = in_q.right_cmd;
            out_d = '{left_drive: left_fin, right_drive: right_fin, bridge_bits: bridge_fin};
          end
        end
      end
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_el_q   <= 1'b0;
      prev_er_q   <= 1'b0;
      lcnt_q      <= 32'sd0;
      rcnt_q      <= 32'sd0;
      errn_q      <= 32'sd0;
      errb_q      <= 32'sd0;
      esum_q      <= 32'sd0;
      corr_q      <= 32'sd0;
      start_q     <= 1'b1;
      last_lc_q   <= 8'd0;
      last_rc_q   <= 8'd0;
      last_ld_q   <= 24'd0;
      last_br_q   <= BridgeStop;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_el_q   <= prev_el_d;
      prev_er_q   <= prev_er_d;
      lcnt_q      <= lcnt_d;
      rcnt_q      <= rcnt_d;
      errn_q      <= errn_d;
      errb_q      <= errb_d;
      esum_q      <= esum_d;
      corr_q      <= corr_d;
      start_q     <= start_d;
      last_lc_q   <= last_lc_d;
      last_rc_q   <= last_rc_d;
      last_ld_q   <= last_ld_d;
      last_br_q   <= last_br_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    rot_q   <= rot_d;
    acc_q   <= acc_d;
    left_q  <= left_d;
    right_q <= right_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/ewsp_checker.sv -----
// Port-level checks of the wheel synchronizing PID, bound to the top level.
module ewsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ewsp_pkg::ewsp_out_t out_data_o
);
  import ewsp_pkg::*;

  // An accepted transaction occupies the sequencer and takes the input out of ready.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transaction");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pending result dropped or changed");

  a_bridge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.bridge_bits == BridgeStop ||
                     out_data_o.bridge_bits == BridgeFwd ||
                     out_data_o.bridge_bits == BridgeRev))
    else $error("illegal bridge pattern");

  // A stopped bridge never comes with a nonzero drive.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bridge_bits == BridgeStop) |->
      (out_data_o.left_drive == 24'd0 && out_data_o.right_drive == 24'd0))
    else $error("drive nonzero while bridge is stopped");

endmodule

bind encoder_wheel_sync_pid_top ewsp_checker u_ewsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the wheel synchronizing PID block.
`timescale 1ns / 1ps

module tb;
  import ewsp_pkg::*;

  // Predicts the drive results of each tick and checks them in order.
  class drive_scoreboard;
    logic [7:0] gains [6];
    logic [15:0] period;
    logic [23:0] limit;
    logic prev_el, prev_er;
    longint left_count, right_count, err_now, err_before, err_sum, correction;
    bit starting;
    logic [7:0] last_lc, last_rc;
    logic [23:0] last_left;
    logic [3:0] last_bridge;
    ewsp_out_t pending_q[$];
    int errors;
    int checked;

    function void clear_counts();
      left_count = 0; right_count = 0;
      err_now = 0; err_before = 0; err_sum = 0;
    endfunction

    function void reset_state();
      gains = '{FwdPropReset, 8'd0, 8'd0, RevPropReset, 8'd0, 8'd0};
      period = PeriodReset;
      limit = LimitReset;
      prev_el = 0; prev_er = 0;
      clear_counts();
      correction = 0;
      starting = 1;
      last_lc = 0; last_rc = 0; last_left = 0; last_bridge = BridgeStop;
      pending_q.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgPeriod) period = val[15:0];
      else if (idx == CfgLimit) limit = val;
      else gains[idx] = val[7:0];
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint gain_of(int i);
      return longint'($signed(gains[i]));
    endfunction

    function void note_tick(ewsp_in_t t);
      ewsp_out_t r;
      longint left, right, q, d;
      bit lrot, rrot;
      int b;
      if (t.mode_cmd != ModeRun) begin
        last_left = 0;
        r.left_drive = 0; r.right_drive = 0; r.bridge_bits = last_bridge;
        pending_q.push_back(r);
        return;
      end
      if (t.left_cmd == t.right_cmd) begin
        if (last_lc != last_rc) begin
          left_count = 0; right_count = 0;
        end
        lrot = t.enc_left != prev_el;
        rrot = t.enc_right != prev_er;
        if (lrot && t.enc_left) left_count = clip32(left_count + 1);
        if (rrot && t.enc_right) right_count = clip32(right_count + 1);
        prev_el = t.enc_left; prev_er = t.enc_right;
        if (t.right_cmd == 0) begin
          correction = 0;
        end else begin
          err_before = err_now;
          err_now = clip32(right_count - left_count);
          if (lrot || rrot) err_sum = clip32(err_sum + err_now);
          if (t.dir_cmd == DirFwd || t.dir_cmd == DirRev) begin
            b = (t.dir_cmd == DirFwd) ? 0 : 3;
            d = err_now - err_before;
            correction = clip32(gain_of(b) * err_now + gain_of(b + 1) * err_sum
                                + gain_of(b + 2) * d);
          end
        end
        if (starting) begin
          left = longint'(period) * t.left_cmd;
          starting = 0;
          clear_counts();
        end else begin
          q = (period != 0) ? longint'(last_left) / longint'(period) : 0;
          left = (q + correction) * longint'(period);
        end
      end else begin
        left = longint'(period) * t.left_cmd;
      end
      right = longint'(period) * t.right_cmd;
      if (left > longint'(limit)) left = limit;
      else if (left < 0) left = 0;
      if (t.dir_cmd == DirFwd) begin
        r.bridge_bits = BridgeFwd;
      end else if (t.dir_cmd == DirRev) begin
        r.bridge_bits = BridgeRev;
      end else begin
        clear_counts();
        left = 0; right = 0;
        r.bridge_bits = BridgeStop;
      end
      last_left = left[23:0];
      last_bridge = r.bridge_bits;
      if (left == 0 && right == 0) starting = 1;
      last_lc = t.left_cmd; last_rc = t.right_cmd;
      r.left_drive = last_left;
      r.right_drive = right[23:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(ewsp_out_t got);
      ewsp_out_t want;
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.left_drive !== want.left_drive) begin
        $display("%0t: left_drive exp %0d got %0d", $time, want.left_drive, got.left_drive);
        errors++;
      end
      if (got.right_drive !== want.right_drive) begin
        $display("%0t: right_drive exp %0d got %0d", $time, want.right_drive,
                 got.right_drive);
        errors++;
      end
      if (got.bridge_bits !== want.bridge_bits) begin
        $display("%0t: bridge_bits exp %h got %h", $time, want.bridge_bits,
                 got.bridge_bits);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  ewsp_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  ewsp_out_t out_data_o;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgFwdProp;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  drive_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int ticks_sent = 0;

  encoder_wheel_sync_pid_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Receiver: decides ready each cycle and checks accepted results.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Notes accepted ticks in the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_tick(in_data_i);
  end

  // Valid drops after each transaction before the next one is offered.
  task automatic send_tick(ewsp_in_t t);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1;
    in_data_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 0;
    ticks_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic ewsp_in_t make_tick(logic [7:0] l, logic [7:0] r, logic [7:0] d,
                                         logic [7:0] m, logic el, logic er);
    ewsp_in_t t;
    t.enc_left = el; t.enc_right = er;
    t.left_cmd = l; t.right_cmd = r; t.dir_cmd = d; t.mode_cmd = m;
    return t;
  endfunction

  // Mostly equal duties in run mode with toggling encoders, so the PID path stays busy.
  function automatic ewsp_in_t rand_tick();
    ewsp_in_t t;
    int k;
    t = ewsp_in_t'({$urandom, $urandom});
    k = $urandom_range(99);
    if (k < 85) begin
      t.mode_cmd = ModeRun;
      if ($urandom_range(9) < 8) t.right_cmd = t.left_cmd;
      if ($urandom_range(9) < 6) t.left_cmd = 8'($urandom_range(20));
      if ($urandom_range(9) < 6) t.right_cmd = t.left_cmd;
      if (k < 78) t.dir_cmd = 8'($urandom_range(1, 2));
      else if (k < 81) t.dir_cmd = 0;
    end
    return t;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_tick(rand_tick());
  endtask

  task automatic random_gains();
    for (int i = 0; i < 6; i++) write_reg(CfgIdxW'(i), CfgDataW'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: start seeding, edges, stop, idle mode, extremes of every field.
    send_tick(make_tick(10, 10, DirFwd, ModeRun, 0, 0));
    send_tick(make_tick(10, 10, DirFwd, ModeRun, 1, 0));
    send_tick(make_tick(10, 10, DirFwd, ModeRun, 0, 1));
    send_tick(make_tick(10, 10, DirFwd, ModeRun, 1, 1));
    send_tick(make_tick(10, 10, DirRev, ModeRun, 0, 1));
    send_tick(make_tick(0, 0, DirFwd, ModeRun, 1, 0));
    send_tick(make_tick(255, 7, DirRev, ModeRun, 0, 0));
    send_tick(make_tick(255, 255, DirFwd, ModeRun, 1, 1));
    send_tick(make_tick(3, 3, 8'hff, ModeRun, 0, 0));
    send_tick(make_tick(3, 3, DirFwd, 8'hff, 1, 1));
    send_tick(make_tick(3, 3, DirFwd, 8'h00, 0, 0));
    send_tick(make_tick(8'h55, 8'haa, 8'hfe, 8'hfe, 1, 1));
    send_tick(make_tick(8'haa, 8'h55, 8'h01, 8'h01, 0, 0));
    drain();

    // Extreme gains, zero period, full limit.
    for (int i = 0; i < 6; i++)
      write_reg(CfgIdxW'(i), (i % 2) ? 24'h80 : 24'h7f);
    write_reg(CfgPeriod, '0);
    write_reg(CfgLimit, 24'hffffff);
    for (int i = 0; i < 8; i++)
      send_tick(make_tick(9, 9, (i < 4) ? DirFwd : DirRev, ModeRun, i[0], i[1]));
    drain();
    write_reg(CfgPeriod, 24'hffff);
    write_reg(CfgLimit, '0);
    random_phase(60, 0, 0);
    drain();

    write_reg(CfgPeriod, 24'd1);
    write_reg(CfgLimit, 24'hffffff);
    random_gains();
    random_phase(250, 0, 0);
    drain();

    write_reg(CfgPeriod, CfgDataW'($urandom_range(1, 65535)));
    write_reg(CfgLimit, CfgDataW'($urandom_range(0, 24'hffffff)));
    random_gains();
    random_phase(220, 82, 0);
    drain();

    // Reset period and limit; the receiver stalls on most cycles while the sender offers without pause.
    write_reg(CfgPeriod, 24'(PeriodReset));
    write_reg(CfgLimit, LimitReset);
    random_gains();
    random_phase(220, 0, 82);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(30, 0, 0);
    join
    drain();

    write_reg(CfgPeriod, CfgDataW'($urandom_range(1, 2000)));
    random_gains();
    random_phase(250, 28, 28);
    drain();

    $display("tb: %0d ticks sent, %0d results checked over 7 settings", ticks_sent,
             sb.checked);
    $display("tb: phases covered gains at extremes, zero period, stalls and hold-off");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
